[sv/i2cm_pkg.sv]
`timescale 1ns / 1ps
// Shared types and constants for the bit-level I2C master.
// No dependencies; imported by i2cm_step and bit_level_i2c_master.
package i2cm_pkg;

	typedef logic [2:0] func_t;
	typedef logic [4:0] phase_t;
	typedef logic [4:0] wait_t;

	localparam func_t FUNC_NONE  = 3'd0;
	localparam func_t FUNC_START = 3'd1;
	localparam func_t FUNC_STOP  = 3'd2;
	localparam func_t FUNC_WRITE = 3'd3;
	localparam func_t FUNC_READ  = 3'd4;

	localparam phase_t PH_IDLE       = 5'd0;
	localparam phase_t PH_ST_SCL_HI  = 5'd1;
	localparam phase_t PH_ST_SDA_HI  = 5'd2;
	localparam phase_t PH_ST_SDA_LO  = 5'd3;
	localparam phase_t PH_ST_SCL_LO  = 5'd4;
	localparam phase_t PH_SP_SCL_HI  = 5'd5;
	localparam phase_t PH_SP_SDA_LO  = 5'd6;
	localparam phase_t PH_SP_SDA_HI  = 5'd7;
	localparam phase_t PH_SP_SCL_LO  = 5'd8;
	localparam phase_t PH_WR_DATA    = 5'd9;
	localparam phase_t PH_WR_SCL_HI  = 5'd10;
	localparam phase_t PH_WR_SCL_LO  = 5'd11;
	localparam phase_t PH_WR_REL     = 5'd12;
	localparam phase_t PH_WR_ACK_HI  = 5'd13;
	localparam phase_t PH_WR_ACK_SMP = 5'd14;
	localparam phase_t PH_WR_RETAKE  = 5'd15;
	localparam phase_t PH_WR_SDA_LO  = 5'd16;
	localparam phase_t PH_RD_REL     = 5'd17;
	localparam phase_t PH_RD_SAMPLE  = 5'd18;
	localparam phase_t PH_RD_SCL_LO  = 5'd19;
	localparam phase_t PH_RD_RETAKE  = 5'd20;
	localparam phase_t PH_RD_ACK     = 5'd21;
	localparam phase_t PH_RD_ACK_HI  = 5'd22;
	localparam phase_t PH_RD_END     = 5'd23;

	localparam wait_t WAIT_NONE = 5'd0;
	localparam wait_t WAIT_5    = 5'd5;
	localparam wait_t WAIT_10   = 5'd10;
	localparam wait_t WAIT_15   = 5'd15;
	localparam wait_t WAIT_20   = 5'd20;

	localparam logic [9:0] UNIT_TICKS_RESET = 10'd60;
	localparam logic [2:0] LAST_BIT         = 3'd7;

	// One tick of input: command plus sampled line level.
	typedef struct packed {
		func_t      func;
		logic [7:0] wr_data;
		logic       master_ack;
		logic       sda_in;
	} i2cm_item_t;

	// Sequencer state, except the unit tick counter whose width is a parameter.
	typedef struct packed {
		phase_t     phase_step;
		wait_t      wait_units;
		logic [2:0] bit_index;
		logic [7:0] shift_byte;
		func_t      active_command;
		logic       ack_to_send;
		logic       ack_seen;
		logic       scl_level;
		logic       sda_level;
		logic       sda_drive;
		logic [7:0] read_result;
	} i2cm_state_t;

	localparam i2cm_state_t STATE_RESET = '{
		phase_step:     PH_IDLE,
		wait_units:     WAIT_NONE,
		bit_index:      3'd0,
		shift_byte:     8'd0,
		active_command: FUNC_NONE,
		ack_to_send:    1'b0,
		ack_seen:       1'b0,
		scl_level:      1'b1,
		sda_level:      1'b1,
		sda_drive:      1'b1,
		read_result:    8'd0
	};

endpackage

[sv/i2cm_step.sv]
`timescale 1ns / 1ps
// Next-state logic of the I2C master for one tick: command start, unit timing,
// phase actions and phase sequencing. Depends on i2cm_pkg.
module i2cm_step #(
	parameter int UNIT_COUNT_WIDTH = 10
) (
	input  i2cm_pkg::i2cm_state_t        cur,
	input  logic [UNIT_COUNT_WIDTH-1:0]  cur_cnt,
	input  i2cm_pkg::i2cm_item_t         item,
	input  logic [9:0]                   unit_ticks,
	output i2cm_pkg::i2cm_state_t        nxt,
	output logic [UNIT_COUNT_WIDTH-1:0]  nxt_cnt,
	output logic                         done
);
	import i2cm_pkg::*;

	localparam int CW = (UNIT_COUNT_WIDTH > 10) ? UNIT_COUNT_WIDTH : 10;

	logic [CW-1:0]               cmask;
	logic [CW-1:0]               ut_ext;
	logic [CW-1:0]               ulen;
	logic [UNIT_COUNT_WIDTH-1:0] cnt_inc;
	logic                        run;
	phase_t                      st;
	wait_t                       w;

	assign cmask   = CW'({UNIT_COUNT_WIDTH{1'b1}});
	assign ut_ext  = CW'(unit_ticks);
	assign cnt_inc = cur_cnt + 1'b1;

	// Clamp unit length into [1, counter max].
	always_comb begin
		if (ut_ext == '0) begin
			ulen = CW'(1);
		end else if (ut_ext > cmask) begin
			ulen = cmask;
		end else begin
			ulen = ut_ext;
		end
	end

	always_comb begin
		nxt     = cur;
		nxt_cnt = cur_cnt;
		done    = 1'b0;
		run     = 1'b0;
		st      = PH_IDLE;
		w       = WAIT_NONE;

		if (cur.phase_step == PH_IDLE) begin
			case (item.func) inside
				FUNC_START, FUNC_STOP, FUNC_WRITE, FUNC_READ: begin
					nxt.active_command = item.func;
					nxt.bit_index      = 3'd0;
					run                = 1'b1;
				end
				default: ;
			endcase
			case (item.func)
				FUNC_START: st = PH_ST_SCL_HI;
				FUNC_STOP:  st = PH_SP_SCL_HI;
				FUNC_WRITE: begin
					nxt.shift_byte = item.wr_data;
					st             = PH_WR_DATA;
				end
				FUNC_READ: begin
					nxt.shift_byte  = 8'd0;
					nxt.ack_to_send = item.master_ack;
					st              = PH_RD_REL;
				end
				default: st = PH_IDLE;
			endcase
		end else if (CW'(cnt_inc) >= ulen) begin
			// One unit elapsed; advance the phase when the wait runs out.
			nxt_cnt = '0;
			if (cur.wait_units != WAIT_NONE) begin
				nxt.wait_units = cur.wait_units - 5'd1;
			end
			if (nxt.wait_units == WAIT_NONE) begin
				run = 1'b1;
				unique case (cur.phase_step) inside
					PH_ST_SCL_LO, PH_SP_SCL_LO, PH_WR_SDA_LO, PH_RD_END: st = PH_IDLE;
					PH_WR_SCL_LO, PH_RD_SCL_LO: begin
						if (cur.bit_index == LAST_BIT) begin
							st = cur.phase_step + 5'd1;
						end else begin
							nxt.bit_index = cur.bit_index + 3'd1;
							st = (cur.phase_step == PH_WR_SCL_LO) ? PH_WR_DATA : PH_RD_SAMPLE;
						end
					end
					default: st = (cur.phase_step > PH_RD_END) ? PH_IDLE
					                                           : cur.phase_step + 5'd1;
				endcase
			end
		end else begin
			nxt_cnt = cnt_inc;
		end

		if (run) begin
			if (st != PH_IDLE) begin
				nxt.phase_step = st;
				unique case (st)
					PH_ST_SCL_HI:  begin nxt.scl_level = 1'b1; w = WAIT_10; end
					PH_ST_SDA_HI:  begin nxt.sda_level = 1'b1; w = WAIT_20; end
					PH_ST_SDA_LO:  begin nxt.sda_level = 1'b0; w = WAIT_10; end
					PH_ST_SCL_LO:  begin nxt.scl_level = 1'b0; w = WAIT_10; end
					PH_SP_SCL_HI:  begin nxt.scl_level = 1'b1; w = WAIT_5;  end
					PH_SP_SDA_LO:  begin nxt.sda_level = 1'b0; w = WAIT_10; end
					PH_SP_SDA_HI:  begin nxt.sda_level = 1'b1; w = WAIT_10; end
					PH_SP_SCL_LO:  begin nxt.scl_level = 1'b0; w = WAIT_10; end
					PH_WR_DATA: begin
						nxt.sda_level = nxt.shift_byte[LAST_BIT - nxt.bit_index];
						w = WAIT_10;
					end
					PH_WR_SCL_HI:  begin nxt.scl_level = 1'b1; w = WAIT_10; end
					PH_WR_SCL_LO:  begin nxt.scl_level = 1'b0; w = WAIT_10; end
					PH_WR_REL:     begin nxt.sda_drive = 1'b0; w = WAIT_10; end
					PH_WR_ACK_HI:  begin nxt.scl_level = 1'b1; w = WAIT_5;  end
					PH_WR_ACK_SMP: begin
						nxt.ack_seen  = ~item.sda_in;
						nxt.scl_level = 1'b0;
						w = WAIT_20;
					end
					PH_WR_RETAKE:  begin nxt.sda_drive = 1'b1; w = WAIT_10; end
					PH_WR_SDA_LO:  begin nxt.sda_level = 1'b0; w = WAIT_NONE; end
					PH_RD_REL:     begin nxt.sda_drive = 1'b0; w = WAIT_10; end
					PH_RD_SAMPLE: begin
						nxt.shift_byte = {nxt.shift_byte[6:0], item.sda_in};
						nxt.scl_level  = 1'b1;
						w = WAIT_10;
					end
					PH_RD_SCL_LO:  begin nxt.scl_level = 1'b0; w = WAIT_15; end
					PH_RD_RETAKE:  begin nxt.sda_drive = 1'b1; w = WAIT_10; end
					PH_RD_ACK:     begin nxt.sda_level = ~nxt.ack_to_send; w = WAIT_10; end
					PH_RD_ACK_HI:  begin nxt.scl_level = 1'b1; w = WAIT_10; end
					PH_RD_END:     begin nxt.scl_level = 1'b0; w = WAIT_10; end
					default:       w = WAIT_NONE;
				endcase
			end
			// A phase without wait only ever leads back to idle, so finish here.
			if (w == WAIT_NONE) begin
				if (nxt.active_command == FUNC_READ) begin
					nxt.read_result = nxt.shift_byte;
				end
				nxt.phase_step     = PH_IDLE;
				nxt.active_command = FUNC_NONE;
				nxt.wait_units     = WAIT_NONE;
				nxt_cnt            = '0;
				done               = 1'b1;
			end else begin
				nxt.wait_units = w;
				nxt_cnt        = '0;
			end
		end
	end

endmodule

[sv/bit_level_i2c_master.sv]
`timescale 1ns / 1ps
// Top level of the bit-level I2C master: input register, sequencer state,
// result register and configuration register. Depends on i2cm_pkg, i2cm_step.
//
//  channel   | direction | tdata / tuser contents                        | accept
//  ----------+-----------+-----------------------------------------------+--------------
//  s_axis    | in        | tdata: wr_data, master_ack, sda_in; tuser: func | tvalid&tready
//  m_axis    | out       | tdata: scl, sda_out, sda_oe, busy_res,        | tvalid&tready
//            |           |        done_res, ack_ok, rd_data              |
//  cfg       | in        | cfg_wr_data = unit_ticks                      | cfg_wr_en
//
// Each request (one bus tick) passes through the input register, then through the
// sequencer logic into the result register. One request is taken every cycle
// while the result side keeps up; the only limit is the result register, which
// holds when m_axis stalls, and then the input register fills and s_axis_tready drops.
// Reset clears the sequencer to idle with SCL and SDA driven high and
// unit_ticks at 60; no clearing pass is needed.
module bit_level_i2c_master #(
	parameter int UNIT_COUNT_WIDTH = 10
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [15:0] s_axis_tdata,  // [7:0] wr_data, [8] master_ack, [9] sda_in, rest zero
	input  logic [2:0]  s_axis_tuser,  // [2:0] func
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [15:0] m_axis_tdata,  // [0] scl, [1] sda_out, [2] sda_oe, [3] busy_res,
	                                   // [4] done_res, [5] ack_ok, [13:6] rd_data, rest zero
	input  logic        cfg_wr_en,
	input  logic [9:0]  cfg_wr_data
);
	import i2cm_pkg::*;

	i2cm_item_t                  item_s1;
	logic                        valid_s1;
	i2cm_state_t                 state_q;
	logic [UNIT_COUNT_WIDTH-1:0] cnt_q;
	logic [9:0]                  unit_ticks_q;
	logic [15:0]                 res_q;
	logic                        res_valid_q;

	i2cm_state_t                 state_nxt;
	logic [UNIT_COUNT_WIDTH-1:0] cnt_nxt;
	logic                        done_nxt;
	logic                        out_free;
	logic                        advance;

	// The result register is free when empty or being drained this cycle.
	assign out_free      = !res_valid_q || m_axis_tready;
	assign advance       = valid_s1 && out_free;
	assign s_axis_tready = !valid_s1 || out_free;

	assign m_axis_tvalid = res_valid_q;
	assign m_axis_tdata  = res_q;

	// Hold the configuration; a write applies from the next tick the sequencer processes.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			unit_ticks_q <= UNIT_TICKS_RESET;
		end else if (cfg_wr_en) begin
			unit_ticks_q <= cfg_wr_data;
		end
	end

	// Input register: take a request whenever the stage is empty or moves on.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tready && s_axis_tvalid) begin
			item_s1.func       <= s_axis_tuser;
			item_s1.wr_data    <= s_axis_tdata[7:0];
			item_s1.master_ack <= s_axis_tdata[8];
			item_s1.sda_in     <= s_axis_tdata[9];
		end
	end

	i2cm_step #(
		.UNIT_COUNT_WIDTH(UNIT_COUNT_WIDTH)
	) u_step (
		.cur        (state_q),
		.cur_cnt    (cnt_q),
		.item       (item_s1),
		.unit_ticks (unit_ticks_q),
		.nxt        (state_nxt),
		.nxt_cnt    (cnt_nxt),
		.done       (done_nxt)
	);

	// Sequencer state advances exactly once per tick, when its result is stored.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= STATE_RESET;
			cnt_q   <= '0;
		end else if (advance) begin
			state_q <= state_nxt;
			cnt_q   <= cnt_nxt;
		end
	end

	// Result register: drop the valid flag once taken, unless refilled.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (out_free) begin
			res_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			res_q <= {2'b00,
			          state_nxt.read_result,
			          state_nxt.ack_seen,
			          done_nxt,
			          (state_nxt.phase_step != PH_IDLE),
			          state_nxt.sda_drive,
			          state_nxt.sda_level,
			          state_nxt.scl_level};
		end
	end

endmodule
